[src/travelling_wave_displacement_assert.svh]
// ----------------------------------------------------------------------------
// travelling wave displacement assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TRAVELLING_WAVE_DISPLACEMENT_ASSERT_SVH
`define TRAVELLING_WAVE_DISPLACEMENT_ASSERT_SVH

// same-cycle implication
`define TWD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twd check failed");

// implication after a fixed number of cycles
`define TWD_ASSERT_DLY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("twd latency check failed");

`endif

[src/twd_pkg.sv]
// ----------------------------------------------------------------------------
// twd_pkg
// shared widths, constants and tables of the travelling wave displacement block
// ----------------------------------------------------------------------------
package twd_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SINE_STAGES = 16;
   localparam int MAX_STAGES  = 24;
   localparam int CORDIC_CELLS = (SINE_STAGES < MAX_STAGES) ? SINE_STAGES : MAX_STAGES;

   // phase reduction: one conditional subtract of 2pi*2^k per cell, k high to low
   localparam int RED_CELLS = 22;
   localparam int RW        = 58;
   localparam int CW        = 34;

   // cycles from accepted start to result strobe
   localparam int LATENCY = RED_CELLS + CORDIC_CELLS + 7;
   localparam int ENV_DLY = RED_CELLS + CORDIC_CELLS - 2;

   typedef logic [RW-1:0]        red_type;
   typedef logic signed [CW-1:0] cw_type;

   localparam logic signed [63:0] TWO_PI_Q32  = 64'sd26986075409;
   localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
   localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
   localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;
   localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;

   localparam cw_type ATAN_TAB [0:MAX_STAGES-1] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128
   };

endpackage

[src/twd_red_cell.sv]
// ----------------------------------------------------------------------------
// twd_red_cell
// one restoring step of the phase reduction modulo 2pi
// ----------------------------------------------------------------------------
module twd_red_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  twd_pkg::red_type  in_val,
   input  twd_pkg::red_type  modulus,
   output logic              out_valid,
   output twd_pkg::red_type  out_val
);

   logic             valid_ff;
   twd_pkg::red_type val_ff, val_in;

   always_comb begin
      if (in_val >= modulus) begin
         val_in = in_val - modulus;
      end else begin
         val_in = in_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      val_ff <= val_in;
   end

   assign out_valid = valid_ff;
   assign out_val   = val_ff;

endmodule

[src/twd_cordic_cell.sv]
// ----------------------------------------------------------------------------
// twd_cordic_cell
// one rotation step of the sine cordic
// ----------------------------------------------------------------------------
module twd_cordic_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  twd_pkg::cw_type in_x,
   input  twd_pkg::cw_type in_y,
   input  twd_pkg::cw_type in_z,
   input  logic [4:0]      shift_amt,
   input  twd_pkg::cw_type angle,
   output logic            out_valid,
   output twd_pkg::cw_type out_x,
   output twd_pkg::cw_type out_y,
   output twd_pkg::cw_type out_z
);

   logic            valid_ff;
   twd_pkg::cw_type x_ff, y_ff, z_ff;
   twd_pkg::cw_type x_in, y_in, z_in;
   twd_pkg::cw_type xs, ys;

   always_comb begin
      xs = in_x >>> shift_amt;
      ys = in_y >>> shift_amt;
      if (!in_z[twd_pkg::CW-1]) begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - angle;
      end else begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

[src/travelling_wave_displacement.sv]
// ----------------------------------------------------------------------------
// travelling_wave_displacement
// body wave displacement of one point per cycle, quadratic envelope
// ----------------------------------------------------------------------------
// usage:
//  - request: start with req_point_x/y/z and req_sim_time; a transfer happens
//    at a rising edge with start high and busy low; busy stays low, so a new
//    point can be given in every cycle
//  - response: rsp_disp_x/y/z are shown for one cycle with rsp_strobe; the
//    receiver has no way to stall, every result is taken when shown
//  - throughput is one point per cycle; each point passes the input stages,
//    the chain of phase reduction cells (one subtract of a scaled 2pi each),
//    the fold, the chain of cordic cells and the output scaling registers
//  - csr port: csr_valid/csr_ready with csr_index and csr_data, always ready;
//    the user writes registers only while no point is in flight, which the
//    block does not enforce; an index beyond the register list is dropped
//  - reset (synchronous, active high) zeroes every configuration register and
//    empties the pipeline; no result is shown until a new point is taken
// ----------------------------------------------------------------------------
module travelling_wave_displacement (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [19:0] req_point_x,
   input  logic signed [19:0] req_point_y,
   input  logic signed [19:0] req_point_z,
   input  logic [31:0]        req_sim_time,
   output logic               rsp_strobe,
   output logic signed [19:0] rsp_disp_x,
   output logic signed [19:0] rsp_disp_y,
   output logic signed [19:0] rsp_disp_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [59:0]        csr_data
);

   localparam int F       = twd_pkg::FRAC_BITS;
   localparam int NC      = twd_pkg::CORDIC_CELLS;
   localparam int NR      = twd_pkg::RED_CELLS;
   localparam int RW      = twd_pkg::RW;
   localparam int CW      = twd_pkg::CW;
   localparam int EQW     = 72;
   localparam int UQW     = 48 - F;
   localparam int DOT_SHL = (F <= 20) ? 20 - F : 0;
   localparam int DOT_SHR = (F > 20) ? F - 20 : 0;

   // register indexes
   typedef enum logic [2:0] {
      REG_AMP  = 3'd0,
      REG_ORG  = 3'd1,
      REG_AXIS = 3'd2,
      REG_WAVE = 3'd3,
      REG_RATE = 3'd4,
      REG_LEN  = 3'd5,
      REG_INV  = 3'd6
   } reg_idx_type;

   // saturate a wide signed value to 32 and 20 bits
   function automatic logic signed [31:0] sat32(input logic signed [EQW-1:0] v);
      logic signed [31:0] r;
      if (v > EQW'(64'sd2147483647)) begin
         r = 32'sh7fffffff;
      end else if (v < EQW'(-64'sd2147483648)) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [19:0] sat20(input logic signed [EQW-1:0] v);
      logic signed [19:0] r;
      if (v > EQW'(64'sd524287)) begin
         r = 20'sh7ffff;
      end else if (v < EQW'(-64'sd524288)) begin
         r = 20'sh80000;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   logic [59:0] amp_ff, org_ff, axis_ff, wave_ff;
   logic [23:0] rate_ff;
   logic [19:0] len_ff, inv_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff  <= '0;
         org_ff  <= '0;
         axis_ff <= '0;
         wave_ff <= '0;
         rate_ff <= '0;
         len_ff  <= '0;
         inv_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_idx_type'(csr_index))
            REG_AMP:  amp_ff  <= csr_data;
            REG_ORG:  org_ff  <= csr_data;
            REG_AXIS: axis_ff <= csr_data;
            REG_WAVE: wave_ff <= csr_data;
            REG_RATE: rate_ff <= csr_data[23:0];
            REG_LEN:  len_ff  <= csr_data[19:0];
            REG_INV:  inv_ff  <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   logic signed [19:0] a0, a1, a2, ox, oy, oz, ax, ay, az, kx, ky, kz;
   assign a0 = amp_ff[19:0];
   assign a1 = amp_ff[39:20];
   assign a2 = amp_ff[59:40];
   assign ox = org_ff[19:0];
   assign oy = org_ff[39:20];
   assign oz = org_ff[59:40];
   assign ax = axis_ff[19:0];
   assign ay = axis_ff[39:20];
   assign az = axis_ff[59:40];
   assign kx = wave_ff[19:0];
   assign ky = wave_ff[39:20];
   assign kz = wave_ff[59:40];

   // ---------------- stage 0: relative point ----------------
   logic               v0_ff;
   logic signed [20:0] rx_ff, ry_ff, rz_ff;
   logic [31:0]        time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      rx_ff   <= 21'(req_point_x) - 21'(ox);
      ry_ff   <= 21'(req_point_y) - 21'(oy);
      rz_ff   <= 21'(req_point_z) - 21'(oz);
      time_ff <= req_sim_time;
   end

   // ---------------- stage 1: products ----------------
   logic               v1_ff;
   logic signed [40:0] px_ff, py_ff, pz_ff;
   logic [55:0]        wt_ff;
   logic signed [41:0] ux_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      px_ff <= 41'(kx) * 41'(rx_ff);
      py_ff <= 41'(ky) * 41'(ry_ff);
      pz_ff <= 41'(kz) * 41'(rz_ff);
      wt_ff <= 56'(rate_ff) * 56'(time_ff);
      ux_ff <= 42'(rx_ff) * 42'($signed({1'b0, inv_ff}));
   end

   // ---------------- stage 2: phase and scaled x ----------------
   logic               v2_ff;
   logic [RW-1:0]      phase_ff;
   logic signed [23:0] u_ff;
   logic signed [42:0] dot_sum;
   logic signed [54:0] dot_scaled;
   logic signed [59:0] phase_in;
   logic signed [41:0] u_wide;
   logic signed [23:0] u_in;

   always_comb begin
      dot_sum    = 43'(px_ff) + 43'(py_ff) + 43'(pz_ff);
      dot_scaled = (55'(dot_sum) <<< DOT_SHL) >>> DOT_SHR;
      // offset by 2pi*2^19 keeps the phase non-negative without changing it mod 2pi
      phase_in   = $signed({4'b0, wt_ff}) - 60'(dot_scaled)
                 + 60'(twd_pkg::TWO_PI_Q32 <<< 19);
      u_wide     = ux_ff >>> 12;
      if (u_wide > 42'sd8388607) begin
         u_in = 24'sh7fffff;
      end else if (u_wide < -42'sd8388608) begin
         u_in = 24'sh800000;
      end else begin
         u_in = u_wide[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      phase_ff <= phase_in[RW-1:0];
      u_ff     <= u_in;
   end

   // ---------------- envelope, then delay line up to the sine ----------------
   logic signed [UQW-1:0]  u2_ff;
   logic signed [43:0]     a1u_ff, a1u_d_ff;
   logic signed [UQW+19:0] a2u2_ff;
   logic signed [31:0]     env_ff;
   logic signed [47:0]     usq;
   logic signed [EQW-1:0]  envq;
   logic signed [31:0]     env_dly_ff [0:twd_pkg::ENV_DLY-1];

   always_comb begin
      usq  = 48'(u_ff) * 48'(u_ff);
      envq = (EQW'(a0) <<< F) + EQW'(a1u_d_ff) + EQW'(a2u2_ff);
   end

   always_ff @(posedge clock) begin
      u2_ff    <= UQW'(usq >>> F);
      a1u_ff   <= 44'(a1) * 44'(u_ff);
      a2u2_ff  <= (UQW+20)'(a2) * (UQW+20)'(u2_ff);
      a1u_d_ff <= a1u_ff;
      env_ff   <= sat32(envq >>> F);
      env_dly_ff[0] <= env_ff;
      for (int i = 1; i < twd_pkg::ENV_DLY; i++) begin
         env_dly_ff[i] <= env_dly_ff[i-1];
      end
   end

   // ---------------- phase reduction chain ----------------
   logic             red_vld [0:NR];
   twd_pkg::red_type red_val [0:NR];

   assign red_vld[0] = v2_ff;
   assign red_val[0] = phase_ff;

   for (genvar g = 0; g < NR; g++) begin : g_red
      twd_red_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (red_vld[g]),
         .in_val    (red_val[g]),
         .modulus   (RW'(twd_pkg::TWO_PI_Q32 <<< (NR - 1 - g))),
         .out_valid (red_vld[g+1]),
         .out_val   (red_val[g+1])
      );
   end

   // ---------------- fold into [-pi/2, pi/2] in Q.30 ----------------
   logic               fold_v_ff;
   twd_pkg::cw_type    fold_z_ff;
   logic signed [35:0] zq, zf;

   always_comb begin
      zq = $signed({3'b0, red_val[NR][34:2]});
      if (zq >= 36'(twd_pkg::PI_Q30)) begin
         zq = zq - 36'(twd_pkg::TWO_PI_Q30);
      end
      if (zq > 36'(twd_pkg::HALF_PI_Q30)) begin
         zf = 36'(twd_pkg::PI_Q30) - zq;
      end else if (zq < -36'(twd_pkg::HALF_PI_Q30)) begin
         zf = -36'(twd_pkg::PI_Q30) - zq;
      end else begin
         zf = zq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_v_ff <= 1'b0;
      end else begin
         fold_v_ff <= red_vld[NR];
      end
      fold_z_ff <= zf[CW-1:0];
   end

   // ---------------- cordic chain ----------------
   logic            cr_vld [0:NC];
   twd_pkg::cw_type cr_x   [0:NC];
   twd_pkg::cw_type cr_y   [0:NC];
   twd_pkg::cw_type cr_z   [0:NC];

   assign cr_vld[0] = fold_v_ff;
   assign cr_x[0]   = CW'(twd_pkg::GAIN_Q30);
   assign cr_y[0]   = '0;
   assign cr_z[0]   = fold_z_ff;

   for (genvar g = 0; g < NC; g++) begin : g_cordic
      twd_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cr_vld[g]),
         .in_x      (cr_x[g]),
         .in_y      (cr_y[g]),
         .in_z      (cr_z[g]),
         .shift_amt (5'(g)),
         .angle     (twd_pkg::ATAN_TAB[g]),
         .out_valid (cr_vld[g+1]),
         .out_x     (cr_x[g+1]),
         .out_y     (cr_y[g+1]),
         .out_z     (cr_z[g+1])
      );
   end

   // ---------------- output scaling ----------------
   logic               m1_v_ff, m2_v_ff, out_v_ff;
   logic signed [31:0] t1_ff, t2_ff;
   logic signed [19:0] dx_ff, dy_ff, dz_ff;
   logic signed [EQW-1:0] t1_prod, t2_prod;

   always_comb begin
      t1_prod = EQW'(env_dly_ff[twd_pkg::ENV_DLY-1]) * EQW'(cr_y[NC]);
      t2_prod = EQW'(t1_ff) * EQW'($signed({1'b0, len_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         m1_v_ff  <= cr_vld[NC];
         m2_v_ff  <= m1_v_ff;
         out_v_ff <= m2_v_ff;
      end
      t1_ff <= sat32(t1_prod >>> 30);
      t2_ff <= sat32(t2_prod >>> F);
      dx_ff <= sat20((EQW'(ax) * EQW'(t2_ff)) >>> F);
      dy_ff <= sat20((EQW'(ay) * EQW'(t2_ff)) >>> F);
      dz_ff <= sat20((EQW'(az) * EQW'(t2_ff)) >>> F);
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_disp_x = dx_ff;
   assign rsp_disp_y = dy_ff;
   assign rsp_disp_z = dz_ff;

endmodule

[src/twd_checker.sv]
// ----------------------------------------------------------------------------
// twd_checker
// port level checks of the travelling wave displacement block
// ----------------------------------------------------------------------------
`include "travelling_wave_displacement_assert.svh"

module twd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic csr_valid,
   input logic csr_ready
);

   // every accepted point comes out after the fixed latency
   `TWD_ASSERT_DLY(a_lat_hit, clock, reset, start && !busy, twd_pkg::LATENCY, rsp_strobe)

   // no result without a matching accepted point
   `TWD_ASSERT_DLY(a_lat_miss, clock, reset, !(start && !busy), twd_pkg::LATENCY, !rsp_strobe)

   // csr writes are never held off
   `TWD_ASSERT_IMP(a_csr_rdy, clock, reset, csr_valid, csr_ready)

endmodule

bind travelling_wave_displacement twd_checker u_twd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// travelling wave displacement testbench
// drives points through the displacement pipeline under several register
// settings and checks every result against a bit-exact predictor
// ----------------------------------------------------------------------------
module testbench;

   // register indexes
   localparam logic [2:0] REG_COEFFS  = 3'd0;
   localparam logic [2:0] REG_ORIGIN  = 3'd1;
   localparam logic [2:0] REG_AXIS    = 3'd2;
   localparam logic [2:0] REG_WAVE    = 3'd3;
   localparam logic [2:0] REG_OMEGA   = 3'd4;
   localparam logic [2:0] REG_LENGTH  = 3'd5;
   localparam logic [2:0] REG_INVLEN  = 3'd6;
   localparam logic [2:0] REG_UNUSED  = 3'd7;

   localparam longint TWO_PI_Q32_L  = 64'sd26986075409;
   localparam longint PI_Q30_L      = 64'sd3373259426;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam longint TWO_PI_Q30_L  = 64'sd6746518852;
   localparam longint GAIN_Q30_L    = 64'sd652032874;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint S32_MAX = 64'sd2147483647;

   typedef struct packed {
      logic signed [19:0] dx;
      logic signed [19:0] dy;
      logic signed [19:0] dz;
   } disp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [19:0] req_point_x = '0;
   logic signed [19:0] req_point_y = '0;
   logic signed [19:0] req_point_z = '0;
   logic [31:0]        req_sim_time = '0;
   logic               rsp_strobe;
   logic signed [19:0] rsp_disp_x;
   logic signed [19:0] rsp_disp_y;
   logic signed [19:0] rsp_disp_z;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [59:0]        csr_data = '0;

   // predictor copy of the register file
   logic [59:0] coeffs_r, origin_r, axis_r, wave_r;
   logic [23:0] omega_r;
   logic [19:0] length_r, invlen_r;

   disp_type expected_disp[$];
   int       errors = 0;
   int       send_idle_pct = 0;

   travelling_wave_displacement dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic longint fld(logic [59:0] p, int k);
      logic signed [19:0] f;
      f = p[20*k +: 20];
      return longint'(f);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint cordic_sine(longint phase);
      longint r, z, x, y, xs, ys;
      longint atan_v;
      r = phase % TWO_PI_Q32_L;
      if (r < 0) r += TWO_PI_Q32_L;
      z = r >>> 2;
      if (z >= PI_Q30_L) z -= TWO_PI_Q30_L;
      if (z > HALF_PI_Q30_L) z = PI_Q30_L - z;
      else if (z < -HALF_PI_Q30_L) z = -PI_Q30_L - z;
      x = GAIN_Q30_L;
      y = 0;
      for (int i = 0; i < twd_pkg::CORDIC_CELLS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         atan_v = longint'(twd_pkg::ATAN_TAB[i]);
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_v;
         end else begin
            x += ys; y -= xs; z += atan_v;
         end
      end
      return y;
   endfunction

   function automatic disp_type displacement(logic signed [19:0] px, logic signed [19:0] py,
                                             logic signed [19:0] pz, logic [31:0] t);
      longint rel[3], dot, wt, sn, u, u2, envq, env, t1, t2, d;
      disp_type res;
      rel[0] = longint'(px) - fld(origin_r, 0);
      rel[1] = longint'(py) - fld(origin_r, 1);
      rel[2] = longint'(pz) - fld(origin_r, 2);
      dot = 0;
      for (int k = 0; k < 3; k++) dot += fld(wave_r, k) * rel[k];
      dot = dot * 16;  // q(12+16) to q.32
      wt = longint'({40'd0, omega_r}) * longint'({32'd0, t});
      sn = cordic_sine(wt - dot);
      u = clamp((rel[0] * longint'({44'd0, invlen_r})) >>> 12, -64'sd8388608, 64'sd8388607);
      u2 = (u * u) >>> twd_pkg::FRAC_BITS;
      envq = (fld(coeffs_r, 0) <<< twd_pkg::FRAC_BITS) + fld(coeffs_r, 1) * u
           + fld(coeffs_r, 2) * u2;
      env = clamp(envq >>> twd_pkg::FRAC_BITS, S32_MIN, S32_MAX);
      t1 = clamp((env * sn) >>> 30, S32_MIN, S32_MAX);
      t2 = clamp((t1 * longint'({44'd0, length_r})) >>> twd_pkg::FRAC_BITS,
                 S32_MIN, S32_MAX);
      for (int k = 0; k < 3; k++) begin
         d = clamp((fld(axis_r, k) * t2) >>> twd_pkg::FRAC_BITS, -64'sd524288, 64'sd524287);
         case (k)
            0: res.dx = d[19:0];
            1: res.dy = d[19:0];
            default: res.dz = d[19:0];
         endcase
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic write_reg(logic [2:0] idx, logic [59:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_COEFFS: coeffs_r = val;
         REG_ORIGIN: origin_r = val;
         REG_AXIS:   axis_r   = val;
         REG_WAVE:   wave_r   = val;
         REG_OMEGA:  omega_r  = val[23:0];
         REG_LENGTH: length_r = val[19:0];
         REG_INVLEN: invlen_r = val[19:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sends one point; start stays high into the next call when there is no gap
   task automatic send_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz,
                             logic [31:0] t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_point_x  <= px;
      req_point_y  <= py;
      req_point_z  <= pz;
      req_sim_time <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_disp.push_back(displacement(px, py, pz, t));
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_disp.size() != 0) @(posedge clock);
      repeat (twd_pkg::LATENCY + 5) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      disp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_disp.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            want = expected_disp.pop_front();
            if (rsp_disp_x !== want.dx) begin
               $error("disp_x expected %0d actual %0d", want.dx, rsp_disp_x);
               errors++;
            end
            if (rsp_disp_y !== want.dy) begin
               $error("disp_y expected %0d actual %0d", want.dy, rsp_disp_y);
               errors++;
            end
            if (rsp_disp_z !== want.dz) begin
               $error("disp_z expected %0d actual %0d", want.dz, rsp_disp_z);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- helpers
   function automatic logic [59:0] rand60();
      return 60'({$urandom(), $urandom()});
   endfunction

   function automatic logic [19:0] rand_coord();
      case ($urandom_range(5))
         0: return 20'h80000;
         1: return 20'h7ffff;
         2: return 20'($urandom_range(8191)) - 20'd4096;
         default: return 20'($urandom());
      endcase
   endfunction

   task automatic send_random(int n);
      for (int i = 0; i < n; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), $urandom());
   endtask

   // typical fish-like settings with small random wobble
   task automatic write_moderate();
      write_reg(REG_COEFFS, {20'($urandom_range(4000)), 20'($urandom_range(8000)) - 20'd4000,
                             20'($urandom_range(2000))});
      write_reg(REG_ORIGIN, {20'($urandom_range(4096)), 20'($urandom_range(4096)),
                             20'($urandom_range(65536))});
      write_reg(REG_AXIS,   {20'd0, 20'd65536, 20'($urandom_range(2000))});
      write_reg(REG_WAVE,   {20'($urandom_range(4096)), 20'($urandom_range(4096)),
                             20'($urandom_range(40000))});
      write_reg(REG_OMEGA,  60'($urandom_range(24'hffffff)));
      write_reg(REG_LENGTH, 60'($urandom_range(131072)));
      write_reg(REG_INVLEN, 60'($urandom_range(8192)));
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_registers();
      // all registers zero after reset: displacement must be zero
      send_point(20'h7ffff, 20'h80000, 20'h12345, 32'hffffffff);
      send_point(20'h00000, 20'h00000, 20'h00000, 32'h0);
      drain();
   endtask

   task automatic test_directed();
      write_moderate();
      write_reg(REG_UNUSED, rand60());  // index beyond the list is dropped
      send_point(20'h7ffff, 20'h7ffff, 20'h7ffff, 32'hffffffff);
      send_point(20'h80000, 20'h80000, 20'h80000, 32'h0);
      send_point(20'h00000, 20'h00000, 20'h00000, 32'h00010000);
      send_point(20'hfffff, 20'h00001, 20'hfffff, 32'h80000000);
      drain();
      // zero reciprocal: envelope collapses to its constant term
      write_reg(REG_INVLEN, 60'd0);
      send_point(20'h7ffff, 20'h12345, 20'h80000, 32'h00030000);
      send_point(20'h80000, 20'h00000, 20'h7ffff, 32'h7fffffff);
      drain();
      // extremes everywhere: large intermediates saturate
      write_reg(REG_COEFFS, {20'h7ffff, 20'h7ffff, 20'h7ffff});
      write_reg(REG_ORIGIN, {20'h80000, 20'h80000, 20'h80000});
      write_reg(REG_AXIS,   {20'h7ffff, 20'h80000, 20'h7ffff});
      write_reg(REG_WAVE,   {20'h80000, 20'h7ffff, 20'h80000});
      write_reg(REG_OMEGA,  60'hffffff);
      write_reg(REG_LENGTH, 60'hfffff);
      write_reg(REG_INVLEN, 60'hfffff);
      for (int i = 0; i < 8; i++) send_point(rand_coord(), rand_coord(), rand_coord(),
                                             i[0] ? 32'hffffffff : 32'($urandom()));
      drain();
      write_reg(REG_COEFFS, {20'h80000, 20'h80000, 20'h80000});
      write_reg(REG_AXIS,   {20'h80000, 20'h7ffff, 20'h80000});
      write_reg(REG_LENGTH, 60'h00000);  // later factor zero after saturation
      send_point(20'h7ffff, 20'h80000, 20'h7ffff, 32'hffffffff);
      drain();
      write_reg(REG_LENGTH, 60'h00001);
      send_point(20'h80000, 20'h7ffff, 20'h80000, 32'h00000001);
      drain();
   endtask

   task automatic test_random_phase(int idle_pct, int n);
      send_idle_pct = idle_pct;
      write_moderate();
      send_random(n / 2);
      drain();  // sender holds off until every expected result has come
      for (int k = 0; k < 7; k++) write_reg(3'(k), rand60());
      send_random(n / 2);
      drain();
   endtask

   initial begin
      coeffs_r = '0; origin_r = '0; axis_r = '0; wave_r = '0;
      omega_r = '0; length_r = '0; invlen_r = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_registers();
      test_directed();
      test_random_phase(19, 360);
      test_random_phase(78, 360);
      test_random_phase(0, 360);
      if (errors == 0 && expected_disp.size() == 0) begin
         $display("travelling_wave_displacement test passed");
      end else begin
         $display("travelling_wave_displacement test failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("travelling_wave_displacement test failed");
      $finish;
   end

endmodule
